@@ rtl/tksl_pkg.sv @@
// Shared types and codes for the top-k score list.
package tksl_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int READ_SPAN     = 8;   // positions reachable by the 3-bit read index
    localparam int WIDE_W        = 8;   // working width for count and limit compares
    localparam logic [3:0] KEEP_LIMIT_RESET = 4'd8;

    // Register index within the configuration space.
    localparam logic REG_KEEP_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [7:0]         model_id;
        logic [16:0]        score;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
    } entry_t;

    typedef struct packed {
        logic ins_en;    // insert transaction accepted this cycle
        logic occupied;  // this cell lies below the current count
        logic at_tail;   // this cell is the first free position
    } cell_ctl_t;

endpackage

@@ rtl/tksl_cell.sv @@
// One list cell: holds an entry and shifts or loads it on insert.
module tksl_cell (
    input  logic                aclk,
    input  tksl_pkg::cell_ctl_t ctl,
    input  tksl_pkg::entry_t    new_entry,
    input  tksl_pkg::entry_t    left_entry,
    input  logic                left_lower,
    output tksl_pkg::entry_t    entry,
    output logic                lower,
    output logic                take_new
);

    tksl_pkg::entry_t entry_reg;
    tksl_pkg::entry_t entry_next;

    // Stored score strictly below the new one: the insert lands here or to the left.
    assign lower    = ctl.occupied && (entry_reg.score < new_entry.score);
    assign take_new = !left_lower && (lower || ctl.at_tail);
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins_en) begin
            if (left_lower) begin
                entry_next = left_entry;
            end else if (take_new) begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/top_k_score_list_unit.sv @@
// Top level of the top-k score list: cell chain, count, result register, APB port.
//
// Usage:
//   Input channel (s_*): one transaction per item with an op code. Insert
//   places the entry in front of the first stored entry of strictly lower
//   score; clear empties the list; read returns the entry at s_read_index;
//   op three only reports the count.
//   Result channel (m_*): exactly one result transaction per input item, in
//   order. The result is registered, so m_valid rises in the cycle after
//   input acceptance.
//   Throughput: one item per cycle. Every cell compares its score with the
//   new one in parallel and shifts into its right neighbor in the same edge.
//   A new item is accepted while the result register is empty or is being
//   taken in the same cycle; when the receiver stalls, s_ready drops and
//   the list holds its contents.
//   APB: keep_limit at byte address 0 (reset 8, zero disables insertion).
//   Write it only while the block is idle. pready is always high.
//   Reset (aresetn low, synchronous): list count goes to zero, the result
//   register empties and keep_limit returns to 8. Entry storage is not
//   cleared; only positions below the count are ever returned.
module top_k_score_list_unit #(
    parameter int DEPTH = tksl_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_model_id,
    input  logic [16:0]        s_score,
    input  logic signed [15:0] s_center_x,
    input  logic signed [15:0] s_center_y,
    input  logic [2:0]         s_read_index,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_entry_valid,
    output logic [7:0]         m_out_model_id,
    output logic [16:0]        m_out_score,
    output logic signed [15:0] m_out_center_x,
    output logic signed [15:0] m_out_center_y,
    output logic [3:0]         m_list_count,
    output logic [3:0]         m_insert_position,
    output logic               m_entry_dropped,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int WW   = tksl_pkg::WIDE_W;
    localparam int RD_N = (DEPTH < tksl_pkg::READ_SPAN) ? DEPTH : tksl_pkg::READ_SPAN;

    // ---------------- configuration ----------------
    logic [3:0] keep_limit_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tksl_pkg::REG_KEEP_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_limit_reg <= tksl_pkg::KEEP_LIMIT_RESET;
        end else if (cfg_wr) begin
            keep_limit_reg <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tksl_pkg::REG_KEEP_LIMIT) begin
            prdata = 32'(keep_limit_reg);
        end
    end

    // ---------------- input decode ----------------
    tksl_pkg::op_t    op;
    tksl_pkg::entry_t new_entry;
    logic             s_fire;
    logic [WW-1:0]    lim_w;
    logic             ins_en;

    assign op       = tksl_pkg::op_t'(s_op);
    assign s_ready  = !m_valid || m_ready;
    assign s_fire   = s_valid && s_ready;

    assign new_entry.model_id = s_model_id;
    assign new_entry.score    = s_score;
    assign new_entry.center_x = s_center_x;
    assign new_entry.center_y = s_center_y;

    // Effective limit: the smaller of keep_limit and the list depth.
    assign lim_w  = (WW'(keep_limit_reg) < WW'(DEPTH)) ? WW'(keep_limit_reg) : WW'(DEPTH);
    assign ins_en = s_fire && (op == tksl_pkg::OP_INSERT) && (lim_w != '0);

    // ---------------- cell chain ----------------
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    tksl_pkg::entry_t cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_lower;
    logic [DEPTH-1:0] cell_take;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tksl_pkg::cell_ctl_t ctl;
        tksl_pkg::entry_t    left_entry;
        logic                left_lower;

        assign ctl.ins_en   = ins_en;
        assign ctl.occupied = CW'(g) < count_reg;
        assign ctl.at_tail  = CW'(g) == count_reg;

        if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_lower = 1'b0;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_lower = cell_lower[g-1];
        end

        tksl_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .left_entry (left_entry),
            .left_lower (left_lower),
            .entry      (cell_entry[g]),
            .lower      (cell_lower[g]),
            .take_new   (cell_take[g])
        );
    end

    // Encode the one cell that takes the new entry; none means position = count.
    logic [CW-1:0] pos_enc;
    logic [CW-1:0] ins_pos;

    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_take[i]) begin
                pos_enc = pos_enc | CW'(i);
            end
        end
    end

    assign ins_pos = (|cell_take) ? pos_enc : count_reg;

    // ---------------- count update ----------------
    logic [WW-1:0] grown_w;
    logic          drop;

    assign grown_w = WW'(count_reg) + WW'(1);
    assign drop    = grown_w > lim_w;

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            unique case (op)
                tksl_pkg::OP_INSERT: begin
                    if (ins_en && !drop) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                tksl_pkg::OP_CLEAR: count_next = '0;
                tksl_pkg::OP_READ:  count_next = count_reg;
                tksl_pkg::OP_NOP:   count_next = count_reg;
                default:            count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------- read select ----------------
    tksl_pkg::entry_t rd_entry;
    logic             rd_hit;

    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (s_read_index == 3'(i)) begin
                rd_entry = cell_entry[i];
            end
        end
    end

    assign rd_hit = (op == tksl_pkg::OP_READ) && (WW'(s_read_index) < WW'(count_reg));

    // ---------------- result register ----------------
    logic             m_valid_reg;
    logic             entry_valid_reg;
    tksl_pkg::entry_t out_entry_reg;
    logic [3:0]       list_count_reg;
    logic [3:0]       insert_position_reg;
    logic             entry_dropped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload holds until the next accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            entry_valid_reg     <= rd_hit;
            out_entry_reg       <= rd_hit ? rd_entry : '0;
            list_count_reg      <= 4'(count_next);
            insert_position_reg <= ins_en ? 4'(WW'(ins_pos)) : 4'd0;
            entry_dropped_reg   <= ins_en && drop;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_entry_valid     = entry_valid_reg;
    assign m_out_model_id    = out_entry_reg.model_id;
    assign m_out_score       = out_entry_reg.score;
    assign m_out_center_x    = out_entry_reg.center_x;
    assign m_out_center_y    = out_entry_reg.center_y;
    assign m_list_count      = list_count_reg;
    assign m_insert_position = insert_position_reg;
    assign m_entry_dropped   = entry_dropped_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(count_reg) <= WW'(DEPTH))
        else $error("list count exceeds depth");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |-> $onehot0(cell_take))
        else $error("more than one cell loads the new entry");

    a_drop_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ins_en && drop) |=> (count_reg == $past(count_reg)))
        else $error("count changed on an insert that dropped an entry");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (op == tksl_pkg::OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the list");

endmodule

@@ sim/tksl_checker.sv @@
// Checker for the top-k score list: tracks the list, predicts every result and compares.
`timescale 1ns / 100ps

module tksl_checker #(
    parameter int DEPTH = tksl_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_model_id,
    input  logic [16:0]        s_score,
    input  logic signed [15:0] s_center_x,
    input  logic signed [15:0] s_center_y,
    input  logic [2:0]         s_read_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_entry_valid,
    input  logic [7:0]         m_out_model_id,
    input  logic [16:0]        m_out_score,
    input  logic signed [15:0] m_out_center_x,
    input  logic signed [15:0] m_out_center_y,
    input  logic [3:0]         m_list_count,
    input  logic [3:0]         m_insert_position,
    input  logic               m_entry_dropped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 drop_count,
    output int                 hit_count
);

    typedef struct packed {
        logic               entry_valid;
        logic [7:0]         model_id;
        logic [16:0]        score;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [3:0]         count;
        logic [3:0]         position;
        logic               dropped;
    } list_report_t;

    tksl_pkg::entry_t slots [DEPTH];
    logic [3:0]       fill;
    logic [3:0]       keep_lim;
    list_report_t     report_q [$];
    list_report_t     got_r;
    list_report_t     want_r;

    // Apply one transaction to the tracked list and return the result it yields.
    function automatic list_report_t apply_list_item(input tksl_pkg::op_t op,
                                                     input tksl_pkg::entry_t cand,
                                                     input logic [2:0] idx);
        list_report_t r;
        int           lim;
        int           pos;
        int           i;
        logic [3:0]   grown;
        r   = '0;
        lim = (keep_lim < DEPTH) ? int'(keep_lim) : DEPTH;
        case (op)
            tksl_pkg::OP_INSERT: begin
                if (lim != 0) begin
                    // first entry with a strictly lower score, else behind the tail
                    pos = fill;
                    for (i = 0; i < fill; i++)
                        if (pos == fill && slots[i].score < cand.score)
                            pos = i;
                    for (i = fill; i > pos; i--)
                        if (i < DEPTH)
                            slots[i] = slots[i - 1];
                    if (pos < DEPTH)
                        slots[pos] = cand;
                    grown = fill + 4'd1;
                    if (grown > lim) begin
                        grown     = grown - 4'd1;
                        r.dropped = 1'b1;
                    end
                    fill       = grown;
                    r.position = 4'(pos);
                end
            end
            tksl_pkg::OP_CLEAR: fill = '0;
            tksl_pkg::OP_READ: begin
                if (idx < fill) begin
                    r.entry_valid = 1'b1;
                    r.model_id    = slots[idx].model_id;
                    r.score       = slots[idx].score;
                    r.center_x    = slots[idx].center_x;
                    r.center_y    = slots[idx].center_y;
                end
            end
            default: ;
        endcase
        r.count = fill;
        return r;
    endfunction

    function automatic string describe(input list_report_t r);
        return $sformatf("valid=%0d id=%0d score=%0d cx=%0d cy=%0d count=%0d pos=%0d drop=%0d",
                         r.entry_valid, r.model_id, r.score, r.center_x, r.center_y,
                         r.count, r.position, r.dropped);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill         = '0;
            keep_lim     = tksl_pkg::KEEP_LIMIT_RESET;
            fail_count   = 0;
            result_count = 0;
            drop_count   = 0;
            hit_count    = 0;
            report_q.delete();
        end else begin
            if (s_valid && s_ready)
                report_q = {report_q, apply_list_item(tksl_pkg::op_t'(s_op),
                    '{s_model_id, s_score, s_center_x, s_center_y}, s_read_index)};
            if (m_valid && m_ready) begin
                got_r.entry_valid = m_entry_valid;
                got_r.model_id    = m_out_model_id;
                got_r.score       = m_out_score;
                got_r.center_x    = m_out_center_x;
                got_r.center_y    = m_out_center_y;
                got_r.count       = m_list_count;
                got_r.position    = m_insert_position;
                got_r.dropped     = m_entry_dropped;
                result_count++;
                if (report_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no transaction pending: %s",
                                 $realtime, describe(got_r));
                end else begin
                    want_r = report_q.pop_front();
                    if (got_r !== want_r) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch, expected %s", $realtime, describe(want_r));
                            $display("%0t:           actual   %s", $realtime, describe(got_r));
                        end
                    end else begin
                        if (got_r.dropped)
                            drop_count++;
                        if (got_r.entry_valid)
                            hit_count++;
                    end
                end
            end
            if (psel && penable && pready && paddr == {tksl_pkg::REG_KEEP_LIMIT, 2'b00}) begin
                if (pwrite) begin
                    keep_lim = pwdata[3:0];
                end else if (prdata[3:0] !== keep_lim) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: keep_limit readback expected %0d, actual %0d",
                                 $realtime, keep_lim, prdata[3:0]);
                end
            end
        end
        pending = report_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the top-k score list: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 64;
    localparam int PHASE_ITEMS   = 115;
    localparam int PHASE_COUNT   = 9;

    typedef struct {
        tksl_pkg::op_t      op;
        logic [7:0]         model_id;
        logic [16:0]        score;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [2:0]         read_index;
    } list_txn_t;

    // Every input driven to a known value from time zero.
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = 2'd0;
    logic [7:0]         s_model_id = '0;
    logic [16:0]        s_score = '0;
    logic signed [15:0] s_center_x = '0;
    logic signed [15:0] s_center_y = '0;
    logic [2:0]         s_read_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_entry_valid;
    logic [7:0]         m_out_model_id;
    logic [16:0]        m_out_score;
    logic signed [15:0] m_out_center_x;
    logic signed [15:0] m_out_center_y;
    logic [3:0]         m_list_count;
    logic [3:0]         m_insert_position;
    logic               m_entry_dropped;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int result_count;
    int drop_count;
    int hit_count;

    // Idle knobs for the current phase, in percent.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Long receiver hold-off: the sender bumps the request, the receiver serves it.
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int unsigned cycle_count = 0;
    int op_sent [4] = '{0, 0, 0, 0};

    always #10 aclk = ~aclk;

    top_k_score_list_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_model_id        (s_model_id),
        .s_score           (s_score),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_read_index      (s_read_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_valid     (m_entry_valid),
        .m_out_model_id    (m_out_model_id),
        .m_out_score       (m_out_score),
        .m_out_center_x    (m_out_center_x),
        .m_out_center_y    (m_out_center_y),
        .m_list_count      (m_list_count),
        .m_insert_position (m_insert_position),
        .m_entry_dropped   (m_entry_dropped),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    tksl_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_model_id        (s_model_id),
        .s_score           (s_score),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_read_index      (s_read_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_valid     (m_entry_valid),
        .m_out_model_id    (m_out_model_id),
        .m_out_score       (m_out_score),
        .m_out_center_x    (m_out_center_x),
        .m_out_center_y    (m_out_center_y),
        .m_list_count      (m_list_count),
        .m_insert_position (m_insert_position),
        .m_entry_dropped   (m_entry_dropped),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .fail_count        (fail_count),
        .pending           (pending),
        .result_count      (result_count),
        .drop_count        (drop_count),
        .hit_count         (hit_count)
    );

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result receiver: drive m_ready at the falling edge. A pending hold request
    // takes priority and keeps m_ready low until the hold_left countdown runs out, so the
    // result register stays full and the block must stall its input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic list_txn_t make_txn(input tksl_pkg::op_t op, input logic [7:0] id,
                                           input logic [16:0] sc, input logic [15:0] cx,
                                           input logic [15:0] cy, input logic [2:0] idx);
        list_txn_t t;
        t.op         = op;
        t.model_id   = id;
        t.score      = sc;
        t.center_x   = cx;
        t.center_y   = cy;
        t.read_index = idx;
        return t;
    endfunction

    // Random transaction. Scores often land on a few shared values so that ties
    // and the Q1.16 extremes show up; fields unused by an op are still random.
    function automatic list_txn_t random_txn(input bit insert_only);
        list_txn_t t;
        int        pick;
        pick = $urandom_range(99);
        if (insert_only || pick < 50)
            t.op = tksl_pkg::OP_INSERT;
        else if (pick < 85)
            t.op = tksl_pkg::OP_READ;
        else if (pick < 90)
            t.op = tksl_pkg::OP_CLEAR;
        else
            t.op = tksl_pkg::OP_NOP;
        t.model_id = 8'($urandom);
        case ($urandom_range(9))
            0:       t.score = 17'd0;
            1:       t.score = 17'd65536;
            2:       t.score = 17'd32768;
            3:       t.score = 17'($urandom_range(3));
            default: t.score = 17'($urandom_range(65536));
        endcase
        t.center_x   = 16'($urandom);
        t.center_y   = 16'($urandom);
        t.read_index = 3'($urandom_range(7));
        return t;
    endfunction

    // Offer one transaction, starting and ending at a falling edge. An idle gap
    // drops valid first; back-to-back transactions keep valid high throughout.
    task automatic send_txn(input list_txn_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= t.op;
        s_model_id   <= t.model_id;
        s_score      <= t.score;
        s_center_x   <= t.center_x;
        s_center_y   <= t.center_y;
        s_read_index <= t.read_index;
        do @(posedge aclk); while (!s_ready);
        op_sent[t.op]++;
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // APB write of keep_limit followed by a readback, which the checker compares.
    task automatic write_keep_limit(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tksl_pkg::REG_KEEP_LIMIT, 2'b00};
        pwdata  <= {28'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        // Phase plan: keep limits cover both extremes, values above the depth and
        // drops below the list count left by the previous phase.
        logic [3:0] phase_limit [PHASE_COUNT];
        int         p;
        int         n;
        phase_limit = '{4'd8, 4'd3, 4'd15, 4'd6, 4'd0, 4'd1, 4'd2, 4'd8, 4'd5};

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset limit of eight.
        send_txn(make_txn(tksl_pkg::OP_READ, 8'd0, 17'd0, 16'd0, 16'd0, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_NOP, 8'hff, 17'h1ffff, 16'hffff, 16'hffff, 3'd7));
        // score and center extremes, then equal scores to check arrival order
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd255, 17'd65536, -16'sd32768, 16'sd32767, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd0, 17'd0, 16'sd32767, -16'sd32768, 3'd7));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd17, 17'd65536, 16'sd5, -16'sd5, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd18, 17'd0, -16'sd1, 16'sd1, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd40, 17'd30000, 16'sd100, 16'sd200, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd41, 17'd30000, 16'sd101, 16'sd201, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd42, 17'd500, 16'sd102, 16'sd202, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd43, 17'd65535, 16'sd103, 16'sd203, 3'd0));
        // list is full: one insert lands behind the tail, one pushes the tail out
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd60, 17'd0, 16'sd7, 16'sd7, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_INSERT, 8'd61, 17'd65536, 16'sd8, 16'sd8, 3'd0));
        for (n = 0; n < 8; n++)
            send_txn(make_txn(tksl_pkg::OP_READ, 8'd0, 17'd0, 16'd0, 16'd0, 3'(n)));
        send_txn(make_txn(tksl_pkg::OP_CLEAR, 8'd0, 17'd0, 16'd0, 16'd0, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_READ, 8'd0, 17'd0, 16'd0, 16'd0, 3'd0));
        send_txn(make_txn(tksl_pkg::OP_NOP, 8'd0, 17'd0, 16'd0, 16'd0, 3'd0));
        wait_drained();

        // Random phases, cycling through the four idle mixes.
        for (p = 0; p < PHASE_COUNT; p++) begin
            write_keep_limit(phase_limit[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while the sender keeps offering
                if (p % 4 == 3 && n == 40)
                    hold_requests++;
                // sender pause until every result is back
                if (p == 1 && n == 60)
                    wait_drained();
                send_txn(random_txn(1'b0));
            end
            // End each phase with a burst of inserts so the next limit starts
            // with a well-filled list.
            for (n = 0; n < 8; n++)
                send_txn(random_txn(1'b1));
            wait_drained();
        end

        repeat (4) @(negedge aclk);
        $display("Covered: %0d inserts, %0d clears, %0d reads, %0d no-ops over %0d limits",
                 op_sent[tksl_pkg::OP_INSERT], op_sent[tksl_pkg::OP_CLEAR],
                 op_sent[tksl_pkg::OP_READ], op_sent[tksl_pkg::OP_NOP], PHASE_COUNT + 1);
        $display("Checked %0d results: %0d tail drops, %0d in-range reads, %0d failures",
                 result_count, drop_count, hit_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
